[hw/rtl/lzss_pkg.sv]
// Shared types and constants for the LZSS window decompressor.
// Used by the front parser, the command queue, the back copier and the top level.
package lzss_pkg;

  // Default window geometry (power of two) and initial write position
  localparam int WINDOW_SIZE_DEF    = 4096;
  localparam int START_POSITION_DEF = 4078;

  // Shortest match a token can describe
  localparam int MATCH_MIN_LEN = 3;

  // Entries in the queue between parser and copier
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_e;

  // One parsed token: literal byte, or match bytes (first = offset low,
  // second = offset high nibble and length nibble)
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        stream_end;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

[hw/rtl/lzss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/lzss_front.sv]
// Front parser: accepts compressed bytes, tracks flags and token phase,
// and pushes literal / match commands. Depends on lzss_pkg.
module lzss_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               queue_full_i,
  output lzss_pkg::cmd_slot_t push_o
);
  import lzss_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TOKEN  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [15:0] flag_shift_q, flag_shift_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic        accept;
  logic [15:0] shifted;
  logic        tok_go;
  logic        tok_bit;
  cmd_kind_e   kind;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign shifted    = flag_shift_q >> 1;

  // Classify the incoming byte
  always_comb begin
    flag_shift_d = flag_shift_q;
    phase_d      = phase_q;
    held_d       = held_q;
    kind         = CMD_NONE;
    tok_go       = 1'b0;
    tok_bit      = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_TOKEN: begin
          tok_go  = 1'b1;
          tok_bit = flag_shift_q[0];
        end
        PH_SECOND: begin
          kind    = CMD_COPY;
          phase_d = PH_IDLE;
        end
        default: begin
          // Idle: fetch a new flag byte once the old one is used up
          flag_shift_d = shifted;
          if (!shifted[8]) begin
            flag_shift_d = {8'hFF, data_byte_i};
            phase_d      = PH_TOKEN;
          end else begin
            tok_go  = 1'b1;
            tok_bit = shifted[0];
          end
        end
      endcase
      if (tok_go) begin
        if (tok_bit) begin
          kind    = CMD_LIT;
          phase_d = PH_IDLE;
        end else begin
          held_d  = data_byte_i;
          phase_d = PH_SECOND;
        end
      end
      // End of stream: drop any partial token
      if (last_byte_i) begin
        flag_shift_d = '0;
        phase_d      = PH_IDLE;
        held_d       = '0;
      end
    end
  end

  // Push a command for every token and for every stream end
  always_comb begin
    push_o.valid           = accept && ((kind != CMD_NONE) || last_byte_i);
    push_o.cmd.kind        = kind;
    push_o.cmd.first_byte  = (kind == CMD_COPY) ? held_q : data_byte_i;
    push_o.cmd.second_byte = data_byte_i;
    push_o.cmd.stream_end  = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_shift_q <= '0;
      phase_q      <= PH_IDLE;
      held_q       <= '0;
    end else begin
      flag_shift_q <= flag_shift_d;
      phase_q      <= phase_d;
      held_q       <= held_d;
    end
  end

endmodule

[hw/rtl/lzss_cmd_queue.sv]
// Small command queue between the front parser and the back copier.
// Depends on lzss_pkg.
module lzss_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzss_pkg::cmd_slot_t push_i,
  input  logic                pop_i,
  output lzss_pkg::cmd_slot_t head_o,
  output logic                full_o
);
  import lzss_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push;
  logic          do_pop;

  assign full_o       = (count_q == FULL_CNT);
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

[hw/rtl/lzss_back.sv]
// Back copier: executes literal and match commands against the history
// window and drives the output register. Depends on lzss_pkg and lzss_ram.
module lzss_back #(
  parameter int WINDOW_SIZE    = lzss_pkg::WINDOW_SIZE_DEF,
  parameter int START_POSITION = lzss_pkg::START_POSITION_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzss_pkg::cmd_slot_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o
);
  import lzss_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] START_PTR = AW'(START_POSITION % WINDOW_SIZE);
  localparam logic [AW:0]   FILL_MAX  = (AW+1)'(WINDOW_SIZE);
  localparam logic [4:0]    CNT_INIT  = 5'(MATCH_MIN_LEN - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW:0]   fill_q, fill_d;
  logic [AW-1:0] src_q, src_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          hit_q, hit_d;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          run_last_q;
  logic          out_free;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          rd_en;
  logic          stream_reset;
  logic [7:0]    rd_data;
  logic [AW-1:0] rel;
  logic [11:0]   offset;

  assign out_free = !out_valid_q || !out_stall_i;
  assign offset   = {head_i.cmd.second_byte[7:4], head_i.cmd.first_byte};
  // Distance of the read address from the stream start
  assign rel      = src_q - START_PTR;

  // Sequence literals and match copies
  always_comb begin
    state_d      = state_q;
    wptr_d       = wptr_q;
    fill_d       = fill_q;
    src_d        = src_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    pop_o        = 1'b0;
    emit         = 1'b0;
    emit_byte    = '0;
    emit_last    = 1'b0;
    rd_en        = 1'b0;
    stream_reset = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.cmd.kind)
            CMD_LIT: begin
              if (out_free) begin
                emit         = 1'b1;
                emit_byte    = head_i.cmd.first_byte;
                emit_last    = 1'b1;
                pop_o        = 1'b1;
                stream_reset = head_i.cmd.stream_end;
              end
            end
            CMD_COPY: begin
              src_d   = AW'(offset);
              cnt_d   = {1'b0, head_i.cmd.second_byte[3:0]} + CNT_INIT;
              state_d = S_RD;
            end
            default: begin
              pop_o        = 1'b1;
              stream_reset = head_i.cmd.stream_end;
            end
          endcase
        end
      end
      S_RD: begin
        // Entries not yet written in this stream read as zero
        rd_en   = 1'b1;
        hit_d   = ({1'b0, rel} < fill_q);
        state_d = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = hit_q ? rd_data : 8'h00;
          emit_last = (cnt_q == '0);
          src_d     = src_q + 1'b1;
          if (cnt_q == '0) begin
            pop_o        = 1'b1;
            stream_reset = head_i.cmd.stream_end;
            state_d      = S_IDLE;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // Advance the write position and the written-region count
    if (emit) begin
      wptr_d = wptr_q + 1'b1;
      if (fill_q != FILL_MAX) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (stream_reset) begin
      wptr_d = START_PTR;
      fill_d = '0;
    end
  end

  lzss_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SIZE)
  ) u_window (
    .clk_i    (clk_i),
    .wr_en_i  (emit),
    .wr_addr_i(wptr_q),
    .wr_data_i(emit_byte),
    .rd_en_i  (rd_en),
    .rd_addr_i(src_q),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= START_PTR;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      fill_q  <= fill_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // Match cursor and output payload
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    cnt_q <= cnt_d;
    hit_q <= hit_d;
    if (emit) begin
      out_byte_q <= emit_byte;
      run_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

endmodule

[hw/rtl/lzss_window_decompressor_top.sv]
// LZSS decompressor with a sliding history window, top level.
// Input channel: one compressed payload byte per transfer (data_byte_i),
// last_byte_i marks the final byte of a stream. Output channel: one
// decompressed byte per transfer, run_last_o set on the last byte that
// an input byte produced.
// A front parser classifies each input byte in the cycle it is taken and
// pushes a command into a two-entry queue; the parser stalls only when
// the queue is full. The back copier emits a literal in the cycle it
// reaches the queue head, if the output register is free; a match of
// length L (3..18) loads the copy cursor, then does one window RAM read
// and one write per byte. Flag bytes produce nothing. With the queue and
// copier idle, a literal passes the queue entry and the output register
// before out_valid_o rises; a match adds the cursor load and RAM read.
// Reset (and every stream end) empties the window logically: a fill
// count tracks the written region, so unwritten positions read as zero
// and no clearing pass is needed. A stall on the output holds the output
// register and the copier; the queue then fills and stalls the input.
// WINDOW_SIZE must be a power of two.
// Depends on lzss_pkg, lzss_front, lzss_cmd_queue, lzss_back.
module lzss_window_decompressor_top #(
  parameter int WINDOW_SIZE    = lzss_pkg::WINDOW_SIZE_DEF,
  parameter int START_POSITION = lzss_pkg::START_POSITION_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  import lzss_pkg::*;

  cmd_slot_t push;
  cmd_slot_t head;
  logic      queue_full;
  logic      pop;

  lzss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .queue_full_i(queue_full),
    .push_o      (push)
  );

  lzss_cmd_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .full_o(queue_full)
  );

  lzss_back #(
    .WINDOW_SIZE   (WINDOW_SIZE),
    .START_POSITION(START_POSITION)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o)
  );

endmodule

[tb/lzss_window_decompressor_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for lzss_window_decompressor_top: streams LZSS payloads through the input
// channel and checks each decompressed byte against an in-bench 4k-window decoder.
// Depends on lzss_pkg and the decompressor RTL.

typedef enum logic [1:0] {
  PHASE_IDLE,
  PHASE_TOKEN,
  PHASE_SECOND
} token_phase_e;

typedef struct packed {
  logic [7:0] value;
  logic       last;
} out_byte_t;

typedef struct packed {
  logic [7:0] data;
  logic       last;
} payload_t;

// Decoder model plus the queue of bytes it predicts
class lzss_scoreboard;
  localparam int WIN_BYTES = lzss_pkg::WINDOW_SIZE_DEF;

  logic [7:0]   hist [WIN_BYTES];
  logic [11:0]  wr_ptr;
  logic [15:0]  flag_sr;
  token_phase_e phase;
  logic [7:0]   held_first;
  out_byte_t    run_q[$];
  out_byte_t    expected_q[$];
  int unsigned  errors;

  function new();
    errors = 0;
    clear_stream();
  endfunction

  // Return to the start of a payload, window included
  function void clear_stream();
    foreach (hist[k]) hist[k] = 8'h00;
    wr_ptr     = 12'(lzss_pkg::START_POSITION_DEF);
    flag_sr    = 16'h0000;
    phase      = PHASE_IDLE;
    held_first = 8'h00;
  endfunction

  // Emit one byte and store it at the write pointer
  function void emit(logic [7:0] b);
    out_byte_t r;
    r.value = b;
    r.last  = 1'b0;
    run_q.push_back(r);
    hist[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  // Literal goes straight out, match first byte is held
  function void take_token(logic [7:0] d);
    if (flag_sr[0]) begin
      emit(d);
      phase = PHASE_IDLE;
    end else begin
      held_first = d;
      phase = PHASE_SECOND;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Note an accepted payload byte and queue the bytes it produces
  function void note_input(logic [7:0] d, logic lst);
    logic [11:0] src;
    int unsigned len;
    run_q.delete();
    case (phase)
      PHASE_TOKEN: take_token(d);
      PHASE_SECOND: begin
        src = {d[7:4], held_first};
        len = d[3:0] + lzss_pkg::MATCH_MIN_LEN;
        // read before write, so overlapping copies repeat fresh bytes
        repeat (len) begin
          emit(hist[src]);
          src = src + 1'b1;
        end
        phase = PHASE_IDLE;
      end
      default: begin
        flag_sr = flag_sr >> 1;
        if (!flag_sr[8]) begin
          flag_sr = {8'hFF, d};
          phase = PHASE_TOKEN;
        end else begin
          take_token(d);
        end
      end
    endcase
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[k]) expected_q.push_back(run_q[k]);
    if (lst) clear_stream();
  endfunction

  // Compare one output transfer with the oldest prediction
  function void check_result(logic [7:0] b, logic l);
    out_byte_t exp_r;
    if (expected_q.size() == 0) begin
      $error("unexpected output: out_byte %02h run_last %0b", b, l);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (b !== exp_r.value) begin
      $error("out_byte: expected %02h, actual %02h", exp_r.value, b);
      errors++;
    end
    if (l !== exp_r.last) begin
      $error("run_last: expected %0b, actual %0b", exp_r.last, l);
      errors++;
    end
  endfunction
endclass

module lzss_window_decompressor_top_tb;

  localparam int unsigned ITEM_TARGET  = 430;
  localparam int unsigned PAUSE_AT     = 250;
  localparam int unsigned HOLD_AT      = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  // Watchdog bound, with a wide margin over the expected run length
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  lzss_scoreboard sb;
  payload_t       payload_q[$];
  int unsigned    cycle_cnt = 0;

  lzss_window_decompressor_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor both channels on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o === 1'b0)
      sb.note_input(data_byte_i, last_byte_i);
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(out_byte_o, run_last_o);
  end

  function automatic void push_payload(logic [7:0] d, logic l);
    payload_t p;
    p.data = d;
    p.last = l;
    payload_q.push_back(p);
  endfunction

  // Offer one byte after a gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] d, input logic l, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every predicted byte has come out
  task automatic wait_drained();
    do @(negedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off
  initial begin : receiver
    int unsigned rx_count;
    int unsigned hold;
    rx_count = 0;
    forever begin
      if (rx_count == HOLD_AT) hold = HOLD_CYCLES;
      else if ((rx_count / 60) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      rx_count++;
    end
  end

  initial begin : main
    int unsigned gap;
    int          base;
    int          stop_at;
    logic [7:0]  flag_bits;
    logic [11:0] pos;
    logic [11:0] ofs;
    logic [3:0]  len_code;

    sb = new();

    // Directed: flags lit/match/lit then five matches
    push_payload(8'h05, 1'b0);
    push_payload(8'h00, 1'b0);  // literal zero at the start position
    push_payload(8'hEE, 1'b0);  // offset 0xFEE, 18 bytes: overlapping copy,
    push_payload(8'hFF, 1'b0);  // write pointer wraps past the top
    push_payload(8'hFF, 1'b0);  // literal all ones
    push_payload(8'h00, 1'b0);  // offset 0, shortest length
    push_payload(8'h00, 1'b0);
    push_payload(8'hFF, 1'b0);  // offset 0xFFF: read wraps to the bottom
    push_payload(8'hF0, 1'b0);
    push_payload(8'h12, 1'b0);
    push_payload(8'h3A, 1'b0);
    push_payload(8'hAB, 1'b0);
    push_payload(8'hCD, 1'b0);
    push_payload(8'h55, 1'b0);
    push_payload(8'hA5, 1'b0);
    push_payload(8'hFF, 1'b1);  // stream ends on a flag byte
    push_payload(8'h00, 1'b0);
    push_payload(8'h34, 1'b1);  // stream ends with half a match
    push_payload(8'hFF, 1'b0);
    push_payload(8'h80, 1'b0);
    push_payload(8'h7F, 1'b1);  // stream ends on a literal
    push_payload(8'h00, 1'b0);
    push_payload(8'h10, 1'b0);
    push_payload(8'h02, 1'b1);  // stream ends on a match

    // Random: mostly well-formed streams, some noise and truncated streams
    while (payload_q.size() < ITEM_TARGET) begin
      base = payload_q.size();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(4, 20))
          push_payload(8'($urandom), ($urandom_range(0, 7) == 0));
      end else begin
        pos = 12'(lzss_pkg::START_POSITION_DEF);
        repeat ($urandom_range(1, 4)) begin
          flag_bits = 8'($urandom);
          push_payload(flag_bits, 1'b0);
          for (int t = 0; t < 8; t++) begin
            if (flag_bits[t]) begin
              push_payload(8'($urandom), 1'b0);
              pos = pos + 1'b1;
            end else begin
              len_code = 4'($urandom);
              // mostly point back into recent output
              if ($urandom_range(0, 3) != 0) ofs = pos - 12'($urandom_range(1, 48));
              else ofs = 12'($urandom);
              push_payload(ofs[7:0], 1'b0);
              push_payload({ofs[11:8], len_code}, 1'b0);
              pos = pos + len_code + 12'(lzss_pkg::MATCH_MIN_LEN);
            end
          end
        end
        // cut some streams short anywhere
        if ($urandom_range(0, 4) == 0) begin
          stop_at = $urandom_range(base, payload_q.size() - 1);
          while (payload_q.size() > stop_at + 1) void'(payload_q.pop_back());
        end
      end
      payload_q[payload_q.size() - 1].last = 1'b1;
    end

    // Reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drive all payload bytes
    for (int i = 0; i < payload_q.size(); i++) begin
      if (i == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 4);
      send_byte(payload_q[i].data, payload_q[i].last, gap);
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
